// File: rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the atlas rectangle packer.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned SizeBits = 13;
  localparam int unsigned BorderBits = 8;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_BORDER       = 2'd2;

  typedef struct packed {
    logic [12:0] rect_width;
    logic [12:0] rect_height;
  } rect_req_t;

  typedef struct packed {
    logic [2:0]  page;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic        new_page;
    logic        overflow;
  } place_res_t;

  typedef struct packed {
    logic start;
    logic cnt_rd;
    logic cnt_load;
    logic node_rd;
    logic node_load;
    logic next_node;
    logic next_page;
    logic rect_rd;
    logic next_rect;
    logic fresh;
    logic set_ovf;
    logic commit;
    logic shift_rd;
    logic shift_wr;
    logic wr_lb;
    logic wr_rt;
    logic finish;
  } arp_cmd_t;

  typedef struct packed {
    logic page_end;
    logic pages_full;
    logic node_end;
    logic fits;
    logic rect_end;
    logic hit;
    logic store_ok;
    logic shift_more;
    logic out_busy;
  } arp_status_t;

endpackage

// File: rtl/arp_ram.sv
// ----------------------------------------------------------------------------
// arp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module arp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/arp_ctrl.sv
// ----------------------------------------------------------------------------
// arp_ctrl
// Sequencer for page, point and rectangle walks, commit, point shifting and writes.
// ----------------------------------------------------------------------------
module arp_ctrl
  import arp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  arp_status_t st_i,
  output arp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PAGE  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;
  localparam logic [3:0] S_NODE  = 4'd3;
  localparam logic [3:0] S_NCHK  = 4'd4;
  localparam logic [3:0] S_RECT  = 4'd5;
  localparam logic [3:0] S_RCHK  = 4'd6;
  localparam logic [3:0] S_CEVAL = 4'd7;
  localparam logic [3:0] S_SHCHK = 4'd8;
  localparam logic [3:0] S_SHWR  = 4'd9;
  localparam logic [3:0] S_PLB   = 4'd10;
  localparam logic [3:0] S_PRT   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_PAGE;
        end
      end
      S_PAGE: begin
        if (st_i.page_end) begin
          if (st_i.pages_full) begin
            cmd_o.set_ovf = 1'b1;
            state_d       = S_FIN;
          end else begin
            cmd_o.fresh = 1'b1;
            state_d     = S_CEVAL;
          end
        end else begin
          cmd_o.cnt_rd = 1'b1;
          state_d      = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.cnt_load = 1'b1;
        state_d        = S_NODE;
      end
      S_NODE: begin
        if (st_i.node_end) begin
          cmd_o.next_page = 1'b1;
          state_d         = S_PAGE;
        end else begin
          cmd_o.node_rd = 1'b1;
          state_d       = S_NCHK;
        end
      end
      S_NCHK: begin
        cmd_o.node_load = 1'b1;
        state_d         = S_RECT;
      end
      S_RECT: begin
        if (!st_i.fits) begin
          cmd_o.next_node = 1'b1;
          state_d         = S_NODE;
        end else if (st_i.rect_end) begin
          state_d = S_CEVAL;
        end else begin
          cmd_o.rect_rd = 1'b1;
          state_d       = S_RCHK;
        end
      end
      S_RCHK: begin
        if (st_i.hit) begin
          cmd_o.next_node = 1'b1;
          state_d         = S_NODE;
        end else begin
          cmd_o.next_rect = 1'b1;
          state_d         = S_RECT;
        end
      end
      S_CEVAL: begin
        if (!st_i.store_ok) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_SHCHK;
        end
      end
      S_SHCHK: begin
        if (st_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHWR;
        end else begin
          state_d = S_PLB;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHCHK;
      end
      S_PLB: begin
        cmd_o.wr_lb = 1'b1;
        state_d     = S_PRT;
      end
      S_PRT: begin
        cmd_o.wr_rt = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!st_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/arp_dp.sv
// ----------------------------------------------------------------------------
// arp_dp
// Datapath: counters, point/rectangle/count stores, tests and result register.
// ----------------------------------------------------------------------------
module arp_dp
  import arp_pkg::*;
#(
  parameter int unsigned MaxPages     = 8,
  parameter int unsigned NodesPerPage = 64,
  parameter int unsigned RectsPerPage = 64,
  parameter int unsigned CoordBits    = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  arp_cmd_t              cmd_i,
  output arp_status_t           st_o,
  input  rect_req_t             in_data_i,
  input  logic [SizeBits-1:0]   atlas_w_i,
  input  logic [SizeBits-1:0]   atlas_h_i,
  input  logic [BorderBits-1:0] border_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output place_res_t            out_data_o
);

  localparam int unsigned PW   = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int unsigned PCW  = $clog2(MaxPages + 1);
  localparam int unsigned NIW  = $clog2(NodesPerPage);
  localparam int unsigned NCW  = $clog2(NodesPerPage + 1);
  localparam int unsigned RIW  = (RectsPerPage > 1) ? $clog2(RectsPerPage) : 1;
  localparam int unsigned RCW  = $clog2(RectsPerPage + 1);
  localparam int unsigned CB   = CoordBits;
  localparam int unsigned RW   = ((CB > SizeBits) ? CB : SizeBits) + 1;
  localparam int unsigned HW   = RW + 1;
  localparam int unsigned NDW  = 2 * CB;
  localparam int unsigned RDW  = 2 * CB + 2 * RW;
  localparam int unsigned CDW  = NCW + RCW;

  logic [SizeBits-1:0] w_q, h_q;
  logic [PCW-1:0]      p_q, pgcnt_q;
  logic [NCW-1:0]      i_q, j_q, cnt_q;
  logic [RCW-1:0]      k_q, pc_q;
  logic [CB-1:0]       x_q, y_q;
  logic                newpg_q, ovf_q;
  logic                out_valid_q;
  place_res_t          out_q;

  logic [NDW-1:0] node_rdata, node_wdata;
  logic [RDW-1:0] rect_rdata;
  logic [CDW-1:0] cnt_rdata;
  logic [NIW-1:0] node_widx, node_ridx;
  logic           node_we;

  logic [RW-1:0]  r_v, b_v;
  logic [HW-1:0]  rb_v, bb_v, xb_v, yb_v, rg_v, bg_v;
  logic           lb_ok, rt_ok;
  logic [1:0]     ins;
  logic [NCW:0]   newcnt;
  logic [CB-1:0]  pl_left, pl_top;
  logic [RW-1:0]  pl_right, pl_bottom;

  assign r_v  = RW'(x_q) + RW'(w_q);
  assign b_v  = RW'(y_q) + RW'(h_q);
  assign rb_v = HW'(r_v) + HW'(border_i);
  assign bb_v = HW'(b_v) + HW'(border_i);
  assign xb_v = HW'(x_q) + HW'(border_i);
  assign yb_v = HW'(y_q) + HW'(border_i);
  assign rg_v = rb_v;
  assign bg_v = bb_v;

  assign rt_ok = (rb_v < HW'(atlas_w_i)) && (yb_v < HW'(atlas_h_i)) && ((rb_v >> CB) == '0);
  assign lb_ok = (xb_v < HW'(atlas_w_i)) && (bb_v < HW'(atlas_h_i)) && ((bb_v >> CB) == '0);
  assign ins   = {1'b0, lb_ok} + {1'b0, rt_ok};
  assign newcnt = {1'b0, cnt_q} - (NCW+1)'(1) + (NCW+1)'(ins);

  assign {pl_left, pl_top, pl_right, pl_bottom} = rect_rdata;

  always_comb begin
    st_o.page_end   = (p_q == pgcnt_q);
    st_o.pages_full = (pgcnt_q == PCW'(MaxPages));
    st_o.node_end   = (i_q >= cnt_q);
    st_o.fits       = (r_v <= RW'(atlas_w_i)) && (b_v <= RW'(atlas_h_i));
    st_o.rect_end   = (k_q >= pc_q);
    st_o.hit        = (HW'(pl_top) < bg_v - HW'(0)) && (HW'(pl_top) < HW'(b_v) + HW'(border_i))
                      && (HW'(pl_bottom) + HW'(border_i) > HW'(y_q))
                      && (HW'(pl_left) < rg_v)
                      && (HW'(pl_right) + HW'(border_i) > HW'(x_q));
    st_o.store_ok   = (pc_q != RCW'(RectsPerPage)) && (newcnt <= (NCW+1)'(NodesPerPage));
    case (ins)
      2'd2:    st_o.shift_more = (j_q > i_q);
      2'd0:    st_o.shift_more = (j_q < cnt_q);
      default: st_o.shift_more = 1'b0;
    endcase
    st_o.out_busy   = out_valid_q;
  end

  always_comb begin
    node_widx  = i_q[NIW-1:0];
    node_wdata = {x_q, CB'(bb_v)};
    node_we    = 1'b0;
    if (cmd_i.shift_wr) begin
      node_we    = 1'b1;
      node_wdata = node_rdata;
      node_widx  = (ins == 2'd2) ? NIW'(j_q + NCW'(1)) : NIW'(j_q - NCW'(1));
    end else if (cmd_i.wr_lb) begin
      node_we = lb_ok;
    end else if (cmd_i.wr_rt) begin
      node_we    = rt_ok;
      node_wdata = {CB'(rb_v), y_q};
      node_widx  = NIW'(i_q + NCW'(lb_ok));
    end
    node_ridx = cmd_i.shift_rd ? j_q[NIW-1:0] : i_q[NIW-1:0];
  end

  arp_ram #(.Width(NDW), .Depth(1 << (PW + NIW))) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i ({p_q[PW-1:0], node_widx}),
    .wdata_i (node_wdata),
    .raddr_i ({p_q[PW-1:0], node_ridx}),
    .rdata_o (node_rdata)
  );

  arp_ram #(.Width(RDW), .Depth(1 << (PW + RIW))) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i ({p_q[PW-1:0], pc_q[RIW-1:0]}),
    .wdata_i ({x_q, y_q, r_v, b_v}),
    .raddr_i ({p_q[PW-1:0], k_q[RIW-1:0]}),
    .rdata_o (rect_rdata)
  );

  arp_ram #(.Width(CDW), .Depth(1 << PW)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (p_q[PW-1:0]),
    .wdata_i ({newcnt[NCW-1:0], pc_q + RCW'(1)}),
    .raddr_i (p_q[PW-1:0]),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q <= in_data_i.rect_width;
      h_q <= in_data_i.rect_height;
    end
    if (cmd_i.cnt_load) begin
      {cnt_q, pc_q} <= cnt_rdata;
    end else if (cmd_i.fresh) begin
      cnt_q <= NCW'(1);
      pc_q  <= '0;
    end
    if (cmd_i.cnt_load || cmd_i.fresh || cmd_i.next_page) begin
      i_q <= '0;
    end else if (cmd_i.next_node) begin
      i_q <= i_q + NCW'(1);
    end
    if (cmd_i.node_load) begin
      {x_q, y_q} <= node_rdata;
      k_q        <= '0;
    end else if (cmd_i.fresh) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cmd_i.next_rect) begin
      k_q <= k_q + RCW'(1);
    end
    if (cmd_i.commit) begin
      j_q <= (ins == 2'd2) ? cnt_q - NCW'(1) : i_q + NCW'(1);
    end else if (cmd_i.shift_wr) begin
      j_q <= (ins == 2'd2) ? j_q - NCW'(1) : j_q + NCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= '0;
      pgcnt_q     <= '0;
      newpg_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.start) begin
        p_q     <= '0;
        newpg_q <= 1'b0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.next_page) begin
        p_q <= p_q + PCW'(1);
      end else if (cmd_i.fresh) begin
        p_q     <= pgcnt_q;
        newpg_q <= 1'b1;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (ovf_q) begin
          out_q <= '{page: '0, pos_x: '0, pos_y: '0, new_page: 1'b0, overflow: 1'b1};
        end else begin
          out_q.page     <= 3'(p_q);
          out_q.pos_x    <= 12'(x_q);
          out_q.pos_y    <= 12'(y_q);
          out_q.new_page <= newpg_q;
          out_q.overflow <= 1'b0;
          if (newpg_q) begin
            pgcnt_q <= pgcnt_q + PCW'(1);
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/atlas_rect_packer_top.sv
// ----------------------------------------------------------------------------
// atlas_rect_packer_top
// Corner-point rectangle packer over a set of atlas pages.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one rectangle size per
// transaction; output channel (out_valid_o/out_ready_i) returns one placement
// per input: page, position, new-page flag, or overflow with all else zero.
// One item is worked on at a time. Each tried page reads its counts, each
// tried point is read and tested against the page's stored rectangles, and a
// commit shifts points and writes the new corner points. The point and
// rectangle stores each have a single, registered read port.
// The result register frees the input side: a new transaction is taken while
// the previous result waits; a stalled receiver holds the next result in the
// final step until the register empties. Reset empties all pages and loads
// width 2048, height 2048, border 1. Configuration writes (cfg_we_i) must
// only be made while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module atlas_rect_packer_top
  import arp_pkg::*;
#(
  parameter int unsigned MAX_PAGES      = 8,
  parameter int unsigned NODES_PER_PAGE = 64,
  parameter int unsigned RECTS_PER_PAGE = 64,
  parameter int unsigned COORD_BITS     = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rect_req_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output place_res_t            out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [SizeBits-1:0]   cfg_wdata_i
);

  logic [SizeBits-1:0]   atlas_w_q, atlas_h_q;
  logic [BorderBits-1:0] border_q;
  arp_cmd_t              cmd;
  arp_status_t           st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= SizeBits'(2048);
      atlas_h_q <= SizeBits'(2048);
      border_q  <= BorderBits'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ATLAS_WIDTH:  atlas_w_q <= cfg_wdata_i;
        CFG_ATLAS_HEIGHT: atlas_h_q <= cfg_wdata_i;
        CFG_BORDER:       border_q  <= cfg_wdata_i[BorderBits-1:0];
        default:          ;
      endcase
    end
  end

  arp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  arp_dp #(
    .MaxPages     (MAX_PAGES),
    .NodesPerPage (NODES_PER_PAGE),
    .RectsPerPage (RECTS_PER_PAGE),
    .CoordBits    (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .atlas_w_i   (atlas_w_q),
    .atlas_h_i   (atlas_h_q),
    .border_i    (border_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
